// ===== rtl/ccs_pkg.sv =====
// Shared types, codes and constants of the cartridge checksum block.
// Used by the front, accumulator, finish and top files; depends on nothing.
package ccs_pkg;

    localparam int WORD_W = 32;
    localparam int SLOT_W = 6;
    localparam int CFG_W  = 2;

    // Configuration register indexes
    localparam logic REG_CIC_VARIANT   = 1'b0;
    localparam logic REG_HALFWORD_SWAP = 1'b1;

    // Item commands
    localparam logic CMD_DATA_WORD  = 1'b0;
    localparam logic CMD_TABLE_LOAD = 1'b1;

    typedef enum logic [1:0] {
        CIC_6102 = 2'd0,
        CIC_6103 = 2'd1,
        CIC_6105 = 2'd2,
        CIC_6106 = 2'd3
    } cic_variant_t;

    localparam logic [WORD_W-1:0] SEED_6102 = 32'hf8ca4ddc;
    localparam logic [WORD_W-1:0] SEED_6103 = 32'ha3886759;
    localparam logic [WORD_W-1:0] SEED_6105 = 32'hdf26f436;
    localparam logic [WORD_W-1:0] SEED_6106 = 32'h1fea617a;

    function automatic logic [WORD_W-1:0] variant_seed(cic_variant_t v);
        logic [WORD_W-1:0] s;
        unique case (v)
            CIC_6102: s = SEED_6102;
            CIC_6103: s = SEED_6103;
            CIC_6105: s = SEED_6105;
            CIC_6106: s = SEED_6106;
            default:  s = SEED_6102;
        endcase
        return s;
    endfunction

    // Input beat payload
    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] data_word;
        logic [SLOT_W-1:0] table_slot;
        logic              last_word;
    } item_t;

    // Result beat payload
    typedef struct packed {
        logic [WORD_W-1:0] checksum_one;
        logic [WORD_W-1:0] checksum_two;
    } result_t;

    // Front end to accumulator stage
    typedef struct packed {
        logic              valid;
        logic              start;
        logic              last;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] table_word;
    } upd_t;

    // Accumulator snapshot at the end of a run
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] acc_sum;
        logic [WORD_W-1:0] carry_count;
        logic [WORD_W-1:0] acc_xor;
        logic [WORD_W-1:0] acc_rot;
        logic [WORD_W-1:0] acc_cond;
        logic [WORD_W-1:0] acc_mix;
    } fin_t;

endpackage

// ===== rtl/ccs_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Payload types come from ccs_pkg at the instance.
interface ccs_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ccs_front.sv =====
// Input register, run/position tracking and boot-code table memory.
// Uses ccs_pkg and ccs_stream_if; feeds ccs_accum.
module ccs_front #(
    parameter int TABLE_WORDS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 halfword_swap,
    ccs_stream_if.sink           item,
    output ccs_pkg::upd_t        upd,
    input  logic                 acc_ready
);
    localparam int IDX_W = $clog2(TABLE_WORDS);

    logic                        in_valid_reg;
    ccs_pkg::item_t              in_reg;
    logic                        run_open_reg;
    logic [IDX_W-1:0]            word_pos_reg;
    logic [ccs_pkg::WORD_W-1:0]  table_mem [TABLE_WORDS];
    logic [ccs_pkg::WORD_W-1:0]  table_q_reg;
    logic                        upd_valid_reg;
    logic                        upd_start_reg;
    logic                        upd_last_reg;
    logic [ccs_pkg::WORD_W-1:0]  upd_word_reg;

    logic                        is_data;
    logic                        is_load;
    logic                        upd_free;
    logic                        advance;
    logic                        in_free;
    logic                        start;
    logic [IDX_W-1:0]            rd_pos;
    logic [ccs_pkg::WORD_W-1:0]  word_sw;

    assign is_data  = in_valid_reg && (in_reg.cmd == ccs_pkg::CMD_DATA_WORD);
    assign is_load  = in_valid_reg && (in_reg.cmd == ccs_pkg::CMD_TABLE_LOAD);
    assign upd_free = !upd_valid_reg || acc_ready;
    assign advance  = is_data && upd_free;
    // a table load always retires from the input register
    assign in_free  = !in_valid_reg || is_load || upd_free;
    assign item.ready = in_free;

    assign start  = !run_open_reg;
    assign rd_pos = start ? '0 : word_pos_reg;

    assign word_sw = halfword_swap
                   ? {in_reg.data_word[23:16], in_reg.data_word[31:24],
                      in_reg.data_word[7:0],   in_reg.data_word[15:8]}
                   : in_reg.data_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_free)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && item.valid)
        begin
            in_reg <= item.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg <= 1'b0;
            word_pos_reg <= '0;
        end
        else if (advance)
        begin
            run_open_reg <= !in_reg.last_word;
            word_pos_reg <= rd_pos + IDX_W'(1);
        end
    end

    // table write port
    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            table_mem[in_reg.table_slot[IDX_W-1:0]] <= in_reg.data_word;
        end
    end

    // table read port, registered
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            table_q_reg <= table_mem[rd_pos];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_valid_reg <= 1'b0;
        end
        else if (upd_free)
        begin
            upd_valid_reg <= is_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            upd_start_reg <= start;
            upd_last_reg  <= in_reg.last_word;
            upd_word_reg  <= word_sw;
        end
    end

    assign upd.valid      = upd_valid_reg;
    assign upd.start      = upd_start_reg;
    assign upd.last       = upd_last_reg;
    assign upd.word       = upd_word_reg;
    assign upd.table_word = table_q_reg;

endmodule

// ===== rtl/ccs_accum.sv =====
// Six checksum accumulators: five update in one stage, the mix sum one stage later.
// Uses ccs_pkg; fed by ccs_front, feeds ccs_finish.
module ccs_accum (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ccs_pkg::cic_variant_t variant,
    input  ccs_pkg::upd_t         upd,
    output logic                  acc_ready,
    output ccs_pkg::fin_t         fin,
    input  logic                  fin_ready
);
    localparam int W = ccs_pkg::WORD_W;

    logic [W-1:0] acc_sum_reg, carry_count_reg, acc_xor_reg;
    logic [W-1:0] acc_rot_reg, acc_cond_reg, acc_mix_reg;

    logic         mix_valid_reg;
    logic         mix_start_reg;
    logic         mix_last_reg;
    logic [W-1:0] mix_op_reg;

    logic         fin_valid_reg;
    logic [W-1:0] fin_sum_reg, fin_carry_reg, fin_xor_reg;
    logic [W-1:0] fin_rot_reg, fin_cond_reg, fin_mix_reg;

    logic [W-1:0] seed;
    logic [W-1:0] base_sum, base_carry, base_xor, base_rot, base_cond;
    logic [W:0]   sum_ext;
    logic [W-1:0] acc_sum_next, carry_count_next, acc_xor_next;
    logic [W-1:0] acc_rot_next, acc_cond_next, mix_op_next;
    logic [2*W-1:0] rot_dbl;
    logic [W-1:0] rot;
    logic [W-1:0] acc_mix_next;
    logic         fin_free;
    logic         adv_upd;
    logic         adv_mix;

    assign seed = ccs_pkg::variant_seed(variant);

    // a run's first word starts from the variant seed
    assign base_sum   = upd.start ? seed : acc_sum_reg;
    assign base_carry = upd.start ? seed : carry_count_reg;
    assign base_xor   = upd.start ? seed : acc_xor_reg;
    assign base_rot   = upd.start ? seed : acc_rot_reg;
    assign base_cond  = upd.start ? seed : acc_cond_reg;

    assign sum_ext          = {1'b0, base_sum} + {1'b0, upd.word};
    assign acc_sum_next     = sum_ext[W-1:0];
    assign carry_count_next = base_carry + {{(W-1){1'b0}}, sum_ext[W]};
    assign acc_xor_next     = base_xor ^ upd.word;

    // rotate left by the word's low five bits
    assign rot_dbl      = {upd.word, upd.word} << upd.word[4:0];
    assign rot          = rot_dbl[2*W-1:W];
    assign acc_rot_next = base_rot + rot;

    assign acc_cond_next = (upd.word < base_cond) ? (base_cond ^ rot)
                                                  : (base_cond ^ acc_sum_next ^ upd.word);

    assign mix_op_next = (variant == ccs_pkg::CIC_6105) ? (upd.table_word ^ upd.word)
                                                        : (upd.word ^ acc_rot_next);

    assign fin_free  = !fin_valid_reg || fin_ready;
    // only a run's last word needs room in the snapshot register
    assign acc_ready = !mix_valid_reg || !mix_last_reg || fin_free;
    assign adv_upd   = upd.valid && acc_ready;
    assign adv_mix   = mix_valid_reg && acc_ready;

    assign acc_mix_next = (mix_start_reg ? seed : acc_mix_reg) + mix_op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_sum_reg     <= ccs_pkg::SEED_6102;
            carry_count_reg <= ccs_pkg::SEED_6102;
            acc_xor_reg     <= ccs_pkg::SEED_6102;
            acc_rot_reg     <= ccs_pkg::SEED_6102;
            acc_cond_reg    <= ccs_pkg::SEED_6102;
        end
        else if (adv_upd)
        begin
            acc_sum_reg     <= acc_sum_next;
            carry_count_reg <= carry_count_next;
            acc_xor_reg     <= acc_xor_next;
            acc_rot_reg     <= acc_rot_next;
            acc_cond_reg    <= acc_cond_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_valid_reg <= 1'b0;
        end
        else if (acc_ready)
        begin
            mix_valid_reg <= upd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_upd)
        begin
            mix_start_reg <= upd.start;
            mix_last_reg  <= upd.last;
            mix_op_reg    <= mix_op_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_mix_reg <= ccs_pkg::SEED_6102;
        end
        else if (adv_mix)
        begin
            acc_mix_reg <= acc_mix_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (fin_free)
        begin
            fin_valid_reg <= mix_valid_reg && mix_last_reg;
        end
    end

    // the other five accumulators already hold the last word's update here
    always_ff @(posedge clk)
    begin
        if (adv_mix && mix_last_reg)
        begin
            fin_sum_reg   <= acc_sum_reg;
            fin_carry_reg <= carry_count_reg;
            fin_xor_reg   <= acc_xor_reg;
            fin_rot_reg   <= acc_rot_reg;
            fin_cond_reg  <= acc_cond_reg;
            fin_mix_reg   <= acc_mix_next;
        end
    end

    assign fin.valid       = fin_valid_reg;
    assign fin.acc_sum     = fin_sum_reg;
    assign fin.carry_count = fin_carry_reg;
    assign fin.acc_xor     = fin_xor_reg;
    assign fin.acc_rot     = fin_rot_reg;
    assign fin.acc_cond    = fin_cond_reg;
    assign fin.acc_mix     = fin_mix_reg;

endmodule

// ===== rtl/ccs_finish.sv =====
// Final combine: multiply or XOR stage, add or XOR stage, result register.
// Uses ccs_pkg and ccs_stream_if; fed by ccs_accum.
module ccs_finish (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ccs_pkg::cic_variant_t variant,
    input  ccs_pkg::fin_t         fin,
    output logic                  fin_ready,
    ccs_stream_if.source          result
);
    localparam int W = ccs_pkg::WORD_W;

    logic           cmb_valid_reg;
    logic           cmb_add_reg;
    logic [W-1:0]   cmb_a1_reg, cmb_b1_reg, cmb_a2_reg, cmb_b2_reg;
    logic           out_valid_reg;
    ccs_pkg::result_t out_reg;

    logic [2*W-1:0] prod1, prod2;
    logic           is_6106;
    logic           add_mode;
    logic           out_free;
    logic [W-1:0]   c1, c2;

    assign prod1    = fin.acc_sum * fin.carry_count;
    assign prod2    = fin.acc_rot * fin.acc_cond;
    assign is_6106  = (variant == ccs_pkg::CIC_6106);
    assign add_mode = is_6106 || (variant == ccs_pkg::CIC_6103);

    assign out_free  = !out_valid_reg || result.ready;
    assign fin_ready = !cmb_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmb_valid_reg <= 1'b0;
        end
        else if (fin_ready)
        begin
            cmb_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_ready && fin.valid)
        begin
            cmb_add_reg <= add_mode;
            cmb_a1_reg  <= is_6106 ? prod1[W-1:0] : (fin.acc_sum ^ fin.carry_count);
            cmb_b1_reg  <= fin.acc_xor;
            cmb_a2_reg  <= is_6106 ? prod2[W-1:0] : (fin.acc_rot ^ fin.acc_cond);
            cmb_b2_reg  <= fin.acc_mix;
        end
    end

    assign c1 = cmb_add_reg ? (cmb_a1_reg + cmb_b1_reg) : (cmb_a1_reg ^ cmb_b1_reg);
    assign c2 = cmb_add_reg ? (cmb_a2_reg + cmb_b2_reg) : (cmb_a2_reg ^ cmb_b2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= cmb_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && cmb_valid_reg)
        begin
            out_reg.checksum_one <= c1;
            out_reg.checksum_two <= c2;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

// ===== rtl/cic_rom_checksum_top.sv =====
// Cartridge image header checksum: top level with configuration registers.
// Throughput: one beat per cycle while no stage stalls, data words and table
// loads alike; the accumulator stage and the single table read port each take
// one word per cycle.
// Reset (rst_n, async): variant and swap clear to 0, pipeline empties, no run open;
// the boot-code table is not cleared and must be loaded before variant 6105 runs.
module cic_rom_checksum_top #(
    parameter int TABLE_WORDS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [ccs_pkg::CFG_W-1:0] cfg_data,
    ccs_stream_if.sink                item,
    ccs_stream_if.source              result
);
    // Pipeline:
    //   input register -> (table read, run start, word position)
    //   update register -> five accumulators update; mix operand registered
    //   mix register -> mix accumulator adds; last word snapshots all six
    //   snapshot -> multiply (6106) or XOR, registered
    //   -> add (6103/6106) or XOR into the result register.
    // Each stage holds while the next one is full and stalled, so the input
    // keeps taking beats while a result waits, until a run's last word finds the
    // snapshot register full. Only the run's last word travels past the mix register.

    ccs_pkg::cic_variant_t variant_reg;
    logic                  halfword_swap_reg;

    ccs_pkg::upd_t         upd;
    logic                  acc_ready;
    ccs_pkg::fin_t         fin;
    logic                  fin_ready;

    // Configuration writes take effect at once; the host must write only while
    // no beat is in flight, which the block itself does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg       <= ccs_pkg::CIC_6102;
            halfword_swap_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ccs_pkg::REG_CIC_VARIANT:
                begin
                    variant_reg <= ccs_pkg::cic_variant_t'(cfg_data[1:0]);
                end
                ccs_pkg::REG_HALFWORD_SWAP:
                begin
                    halfword_swap_reg <= cfg_data[0];
                end
                default:
                begin
                    variant_reg <= variant_reg;
                end
            endcase
        end
    end

    // Input beat register, run tracking and the boot-code table.
    ccs_front #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .halfword_swap (halfword_swap_reg),
        .item          (item),
        .upd           (upd),
        .acc_ready     (acc_ready)
    );

    // Accumulators; the seed is picked at the first word of each run.
    ccs_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .variant   (variant_reg),
        .upd       (upd),
        .acc_ready (acc_ready),
        .fin       (fin),
        .fin_ready (fin_ready)
    );

    // Variant-dependent combine into crc1/crc2 and the result register.
    ccs_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .variant   (variant_reg),
        .fin       (fin),
        .fin_ready (fin_ready),
        .result    (result)
    );

endmodule
